FILE: hdl/pia_pkg.sv
// shared types, register codes and helper functions of the parallel interface adapter
`default_nettype none

package pia_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CA1   = 2'd2;
    localparam logic [1:0] OP_CB1   = 2'd3;

    // register addresses
    localparam logic [1:0] SEL_PORT_A = 2'd0;
    localparam logic [1:0] SEL_CTRL_A = 2'd1;
    localparam logic [1:0] SEL_PORT_B = 2'd2;
    localparam logic [1:0] SEL_CTRL_B = 2'd3;

    // control register bit positions
    localparam int CR_IRQ1  = 7;
    localparam int CR_IRQ2  = 6;
    localparam int CR_C2OUT = 5;
    localparam int CR_C2MAN = 4;
    localparam int CR_C2LVL = 3;
    localparam int CR_DATA  = 2;
    localparam int CR_EDGE  = 1;
    localparam int CR_EN    = 0;

    // cx2 drive codes
    localparam logic [1:0] DRV_INPUT = 2'd0;
    localparam logic [1:0] DRV_LOW   = 2'd1;
    localparam logic [1:0] DRV_HIGH  = 2'd2;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] reg_sel;
        logic [7:0] write_data;
        logic       line_level;
        logic [7:0] pins_a;
        logic [7:0] pins_b;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic [7:0] port_a_latch;
        logic [7:0] port_a_dir;
        logic [7:0] port_b_latch;
        logic [7:0] port_b_dir;
        logic [1:0] ca2_drive;
        logic [1:0] cb2_drive;
    } result_t;

    // cx2 drive after a control write
    function automatic logic [1:0] c2_drive(input logic [7:0] ctrl, input logic [1:0] current);
        logic [1:0] drv;
        begin
            if (!ctrl[CR_C2OUT])
            begin
                drv = DRV_INPUT;
            end
            else if (ctrl[CR_C2MAN])
            begin
                drv = ctrl[CR_C2LVL] ? DRV_HIGH : DRV_LOW;
            end
            else
            begin
                drv = current;
            end
            return drv;
        end
    endfunction

    // true when a cx1 level change is an enabled active edge
    function automatic logic c1_hit(input logic [7:0] ctrl, input logic prev, input logic level);
        logic hit;
        begin
            hit = 1'b0;
            if (prev && !level)
            begin
                hit = ctrl[CR_EN] && !ctrl[CR_EDGE];
            end
            else if (!prev && level)
            begin
                hit = ctrl[CR_EN] && ctrl[CR_EDGE];
            end
            return hit;
        end
    endfunction

    // output latch where direction is 1, pins where it is 0
    function automatic logic [7:0] port_mix(input logic [7:0] latch, input logic [7:0] dir,
                                            input logic [7:0] pins);
        return (dir & latch) | (~dir & pins);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/pia_core.sv
// adapter state registers and the single-pass update for one word
`default_nettype none

module pia_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire pia_pkg::item_t   item,
    output pia_pkg::result_t      result
);
    import pia_pkg::*;

    logic [7:0] out_a_reg, out_a_next;
    logic [7:0] dir_a_reg, dir_a_next;
    logic [7:0] ctrl_a_reg, ctrl_a_next;
    logic [7:0] out_b_reg, out_b_next;
    logic [7:0] dir_b_reg, dir_b_next;
    logic [7:0] ctrl_b_reg, ctrl_b_next;
    logic       prev_ca1_reg, prev_ca1_next;
    logic       prev_cb1_reg, prev_cb1_next;
    logic [1:0] ca2_reg, ca2_next;
    logic [1:0] cb2_reg, cb2_next;
    logic [7:0] rd;

    always_comb
    begin
        out_a_next    = out_a_reg;
        dir_a_next    = dir_a_reg;
        ctrl_a_next   = ctrl_a_reg;
        out_b_next    = out_b_reg;
        dir_b_next    = dir_b_reg;
        ctrl_b_next   = ctrl_b_reg;
        prev_ca1_next = prev_ca1_reg;
        prev_cb1_next = prev_cb1_reg;
        ca2_next      = ca2_reg;
        cb2_next      = cb2_reg;
        rd            = BYTE_ALL_ONES;

        case (item.opcode)
            OP_WRITE:
            begin
                case (item.reg_sel)
                    SEL_PORT_A:
                    begin
                        if (ctrl_a_reg[CR_DATA])
                        begin
                            out_a_next = item.write_data;
                        end
                        else
                        begin
                            dir_a_next = item.write_data;
                        end
                    end
                    SEL_CTRL_A:
                    begin
                        ca2_next    = c2_drive(item.write_data, ca2_reg);
                        ctrl_a_next = {ctrl_a_reg[7:6], item.write_data[5:0]};
                    end
                    SEL_PORT_B:
                    begin
                        if (ctrl_b_reg[CR_DATA])
                        begin
                            out_b_next = item.write_data;
                        end
                        else
                        begin
                            dir_b_next = item.write_data;
                        end
                    end
                    default:
                    begin
                        cb2_next    = c2_drive(item.write_data, cb2_reg);
                        ctrl_b_next = {ctrl_b_reg[7:6], item.write_data[5:0]};
                    end
                endcase
            end
            OP_READ:
            begin
                case (item.reg_sel)
                    SEL_PORT_A:
                    begin
                        if (ctrl_a_reg[CR_DATA])
                        begin
                            rd                   = port_mix(out_a_reg, dir_a_reg, item.pins_a);
                            ctrl_a_next[CR_IRQ1] = 1'b0;
                        end
                        else
                        begin
                            rd = dir_a_reg;
                        end
                    end
                    SEL_CTRL_A:
                    begin
                        rd = ctrl_a_reg;
                    end
                    SEL_PORT_B:
                    begin
                        if (ctrl_b_reg[CR_DATA])
                        begin
                            rd                   = port_mix(out_b_reg, dir_b_reg, item.pins_b);
                            ctrl_b_next[CR_IRQ1] = 1'b0;
                        end
                        else
                        begin
                            rd = dir_b_reg;
                        end
                    end
                    default:
                    begin
                        rd = ctrl_b_reg;
                    end
                endcase
            end
            OP_CA1:
            begin
                if (c1_hit(ctrl_a_reg, prev_ca1_reg, item.line_level))
                begin
                    ctrl_a_next[CR_IRQ1] = 1'b1;
                end
                prev_ca1_next = item.line_level;
            end
            default:
            begin
                if (c1_hit(ctrl_b_reg, prev_cb1_reg, item.line_level))
                begin
                    ctrl_b_next[CR_IRQ1] = 1'b1;
                end
                prev_cb1_next = item.line_level;
            end
        endcase

        result.read_data    = rd;
        result.irq_out      = ctrl_a_next[CR_IRQ1] | ctrl_a_next[CR_IRQ2]
                            | ctrl_b_next[CR_IRQ1] | ctrl_b_next[CR_IRQ2];
        result.port_a_latch = out_a_next;
        result.port_a_dir   = dir_a_next;
        result.port_b_latch = out_b_next;
        result.port_b_dir   = dir_b_next;
        result.ca2_drive    = ca2_next;
        result.cb2_drive    = cb2_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_a_reg    <= '0;
            dir_a_reg    <= BYTE_ALL_ONES;
            ctrl_a_reg   <= '0;
            out_b_reg    <= '0;
            dir_b_reg    <= BYTE_ALL_ONES;
            ctrl_b_reg   <= '0;
            prev_ca1_reg <= 1'b1;
            prev_cb1_reg <= 1'b1;
            ca2_reg      <= DRV_INPUT;
            cb2_reg      <= DRV_INPUT;
        end
        else if (fire)
        begin
            out_a_reg    <= out_a_next;
            dir_a_reg    <= dir_a_next;
            ctrl_a_reg   <= ctrl_a_next;
            out_b_reg    <= out_b_next;
            dir_b_reg    <= dir_b_next;
            ctrl_b_reg   <= ctrl_b_next;
            prev_ca1_reg <= prev_ca1_next;
            prev_cb1_reg <= prev_cb1_next;
            ca2_reg      <= ca2_next;
            cb2_reg      <= cb2_next;
        end
    end

    // irq2 flags have no source
    a_no_irq2: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_a_reg[CR_IRQ2] && !ctrl_b_reg[CR_IRQ2])
        else $error("irq2 flag set");

    // drive codes stay in range
    a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
        ca2_reg != 2'd3 && cb2_reg != 2'd3)
        else $error("cx2 drive code out of range");

    // a port a data read clears irq1 of control a
    a_read_clears_a: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.opcode == OP_READ && item.reg_sel == SEL_PORT_A && ctrl_a_reg[CR_DATA]
        |=> !ctrl_a_reg[CR_IRQ1])
        else $error("port a read left irq1 set");

    // a port b data read clears irq1 of control b
    a_read_clears_b: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.opcode == OP_READ && item.reg_sel == SEL_PORT_B && ctrl_b_reg[CR_DATA]
        |=> !ctrl_b_reg[CR_IRQ1])
        else $error("port b read left irq1 set");

endmodule

`default_nettype wire

FILE: hdl/parallel_interface_adapter.sv
// top level of the two-port parallel interface adapter
`default_nettype none

// Two-port parallel interface adapter, 6821/6520 style. Each input word is a
// bus write, a bus read, or a new CA1/CB1 level; each one yields exactly one
// result word with the read byte (0xff when not a read), the irq line and the
// port, direction and CA2/CB2 drive state after that word. A word is taken
// into an input register, goes through the state update in one pass and lands
// in a result register, from which the result is offered; one word is
// accepted every cycle as long as results are taken. The input register
// advances whenever the result register is empty or being emptied, so a
// waiting result still lets one new word be accepted.
module parallel_interface_adapter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire pia_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output pia_pkg::result_t       result
);
    import pia_pkg::*;

    // input stage
    logic    in_valid_reg;
    item_t   in_word_reg;

    // result stage
    logic    out_valid_reg;
    result_t out_word_reg;

    // result of the single-pass update
    result_t core_result;

    // the held word moves on when the result register is free or being taken
    logic advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    pia_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_word_reg),
        .result (core_result)
    );

    // input register: control cleared by reset, payload loaded on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_word_reg <= item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // a new result only appears when a held word moved on
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result word without a source word");

    // a held word that cannot advance keeps the input side closed
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result_ready |-> !item_ready)
        else $error("input accepted while both stages are blocked");

    // a word leaving the input stage always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced word lost");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// self-checking testbench of the two-port parallel interface adapter
`timescale 1ns / 100ps

module testbench;

    import pia_pkg::*;

    // shadow copy of the adapter registers; predicts one result word per input word
    // and checks each result word against the oldest prediction
    class pia_mirror;
        logic [7:0] out_a;
        logic [7:0] dir_a;
        logic [7:0] ctrl_a;
        logic [7:0] out_b;
        logic [7:0] dir_b;
        logic [7:0] ctrl_b;
        logic       line_a_prev;
        logic       line_b_prev;
        logic [1:0] ca2;
        logic [1:0] cb2;
        result_t    predicted[$];
        int         errors;

        function new();
            out_a       = 8'h00;
            dir_a       = 8'hff;
            ctrl_a      = 8'h00;
            out_b       = 8'h00;
            dir_b       = 8'hff;
            ctrl_b      = 8'h00;
            line_a_prev = 1'b1;
            line_b_prev = 1'b1;
            ca2         = DRV_INPUT;
            cb2         = DRV_INPUT;
            errors      = 0;
        endfunction

        // cx2 line after a control write; handshake or pulse mode keeps the old drive
        function logic [1:0] next_drive(logic [7:0] wr, logic [1:0] now);
            logic [1:0] drv;
            drv = now;
            if (!wr[CR_C2OUT])
            begin
                drv = DRV_INPUT;
            end
            else if (wr[CR_C2MAN])
            begin
                drv = wr[CR_C2LVL] ? DRV_HIGH : DRV_LOW;
            end
            return drv;
        endfunction

        // control register after a cx1 level change; the edge bit names the active level
        function logic [7:0] after_line(logic [7:0] c, logic was, logic level);
            logic [7:0] upd;
            upd = c;
            if (was != level && c[CR_EN] && c[CR_EDGE] == level)
            begin
                upd[CR_IRQ1] = 1'b1;
            end
            return upd;
        endfunction

        function void apply_word(item_t w);
            result_t r;
            r.read_data = BYTE_ALL_ONES;
            case (w.opcode)
                OP_WRITE:
                begin
                    case (w.reg_sel)
                        SEL_PORT_A:
                        begin
                            if (ctrl_a[CR_DATA]) out_a = w.write_data;
                            else dir_a = w.write_data;
                        end
                        SEL_CTRL_A:
                        begin
                            ca2    = next_drive(w.write_data, ca2);
                            ctrl_a = {ctrl_a[CR_IRQ1:CR_IRQ2], w.write_data[CR_C2OUT:CR_EN]};
                        end
                        SEL_PORT_B:
                        begin
                            if (ctrl_b[CR_DATA]) out_b = w.write_data;
                            else dir_b = w.write_data;
                        end
                        default:
                        begin
                            cb2    = next_drive(w.write_data, cb2);
                            ctrl_b = {ctrl_b[CR_IRQ1:CR_IRQ2], w.write_data[CR_C2OUT:CR_EN]};
                        end
                    endcase
                end
                OP_READ:
                begin
                    case (w.reg_sel)
                        SEL_PORT_A:
                        begin
                            if (ctrl_a[CR_DATA])
                            begin
                                r.read_data = (out_a & dir_a) | (w.pins_a & ~dir_a);
                                ctrl_a[CR_IRQ1] = 1'b0;
                            end
                            else
                            begin
                                r.read_data = dir_a;
                            end
                        end
                        SEL_CTRL_A: r.read_data = ctrl_a;
                        SEL_PORT_B:
                        begin
                            if (ctrl_b[CR_DATA])
                            begin
                                r.read_data = (out_b & dir_b) | (w.pins_b & ~dir_b);
                                ctrl_b[CR_IRQ1] = 1'b0;
                            end
                            else
                            begin
                                r.read_data = dir_b;
                            end
                        end
                        default: r.read_data = ctrl_b;
                    endcase
                end
                OP_CA1:
                begin
                    ctrl_a      = after_line(ctrl_a, line_a_prev, w.line_level);
                    line_a_prev = w.line_level;
                end
                default:
                begin
                    ctrl_b      = after_line(ctrl_b, line_b_prev, w.line_level);
                    line_b_prev = w.line_level;
                end
            endcase
            r.irq_out      = |{ctrl_a[CR_IRQ1:CR_IRQ2], ctrl_b[CR_IRQ1:CR_IRQ2]};
            r.port_a_latch = out_a;
            r.port_a_dir   = dir_a;
            r.port_b_latch = out_b;
            r.port_b_dir   = dir_b;
            r.ca2_drive    = ca2;
            r.cb2_drive    = cb2;
            predicted.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                if (errors < 200)
                    $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void compare_word(result_t got);
            result_t want;
            if (predicted.size() == 0)
            begin
                $display("%0t ns: result word with nothing predicted, expected none, got %h",
                         $time, got);
                errors++;
                return;
            end
            want = predicted.pop_front();
            check_field("read_data", want.read_data, got.read_data);
            check_field("irq_out", {7'd0, want.irq_out}, {7'd0, got.irq_out});
            check_field("port_a_latch", want.port_a_latch, got.port_a_latch);
            check_field("port_a_dir", want.port_a_dir, got.port_a_dir);
            check_field("port_b_latch", want.port_b_latch, got.port_b_latch);
            check_field("port_b_dir", want.port_b_dir, got.port_b_dir);
            check_field("ca2_drive", {6'd0, want.ca2_drive}, {6'd0, got.ca2_drive});
            check_field("cb2_drive", {6'd0, want.cb2_drive}, {6'd0, got.cb2_drive});
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    pia_mirror mirror = new();

    // set during the stretch where neither side idles
    logic steady;

    parallel_interface_adapter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run (about 2k words)
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one word and hold it until the handshake; note it once taken
    task automatic send_word(input item_t w);
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        mirror.apply_word(w);
        // occasional gap with valid low
        if (!steady && $urandom_range(99) < 10)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    task automatic put(input logic [1:0] op, input logic [1:0] sel, input logic [7:0] data,
                       input logic level, input logic [7:0] pa, input logic [7:0] pb);
        item_t w;
        w.opcode     = op;
        w.reg_sel    = sel;
        w.write_data = data;
        w.line_level = level;
        w.pins_a     = pa;
        w.pins_b     = pb;
        send_word(w);
    endtask

    // sender stays quiet until every predicted word has come back
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (mirror.predicted.size() != 0) @(posedge clk);
    endtask

    // random word: mostly bus traffic, with a fair share of cx1 line changes
    function automatic item_t random_word();
        item_t w;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 40)
            w.opcode = OP_WRITE;
        else if (pick < 75)
            w.opcode = OP_READ;
        else if (pick < 87)
            w.opcode = OP_CA1;
        else
            w.opcode = OP_CB1;
        w.reg_sel    = 2'($urandom_range(3));
        w.write_data = 8'($urandom_range(255));
        w.line_level = 1'($urandom_range(1));
        w.pins_a     = 8'($urandom_range(255));
        w.pins_b     = 8'($urandom_range(255));
        return w;
    endfunction

    // result side: check every accepted word, stall at random about ten percent of the time outside the steady stretch
    initial
    begin
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                mirror.compare_word(result);
            result_ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        steady     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: reset values, direction vs data select, cx1 edges,
        // flag behavior on control writes and port reads, cx2 modes
        put(OP_READ,  SEL_PORT_A, 8'h00, 1'b0, 8'h00, 8'h00);  // direction read after reset
        put(OP_READ,  SEL_CTRL_A, 8'hff, 1'b1, 8'hff, 8'hff);
        put(OP_WRITE, SEL_PORT_A, 8'h0f, 1'b0, 8'h00, 8'h00);  // direction a
        put(OP_WRITE, SEL_CTRL_A, 8'h07, 1'b0, 8'h00, 8'h00);  // data select, rising, enable
        put(OP_WRITE, SEL_PORT_A, 8'ha5, 1'b0, 8'h00, 8'h00);
        put(OP_READ,  SEL_PORT_A, 8'h00, 1'b0, 8'h3c, 8'h00);  // mixed latch and pins
        put(OP_CA1,   SEL_PORT_A, 8'h00, 1'b0, 8'h00, 8'h00);  // falling, wrong polarity
        put(OP_CA1,   SEL_PORT_A, 8'h00, 1'b1, 8'h00, 8'h00);  // rising, sets flag
        put(OP_CA1,   SEL_PORT_A, 8'h00, 1'b1, 8'h00, 8'h00);  // same level again
        put(OP_WRITE, SEL_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00);  // flag must survive
        put(OP_READ,  SEL_PORT_A, 8'h00, 1'b0, 8'hff, 8'h00);  // direction read keeps flag
        put(OP_READ,  SEL_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00);
        put(OP_WRITE, SEL_CTRL_A, 8'hff, 1'b0, 8'h00, 8'h00);  // cx2 manual high
        put(OP_READ,  SEL_PORT_A, 8'h00, 1'b0, 8'hff, 8'hff);  // data read clears flag
        put(OP_WRITE, SEL_CTRL_A, 8'h30, 1'b0, 8'h00, 8'h00);  // cx2 manual low
        put(OP_WRITE, SEL_CTRL_A, 8'h20, 1'b0, 8'h00, 8'h00);  // handshake mode keeps drive
        put(OP_WRITE, SEL_CTRL_B, 8'h01, 1'b0, 8'h00, 8'h00);  // falling, enable
        put(OP_WRITE, SEL_PORT_B, 8'h00, 1'b0, 8'h00, 8'h00);  // direction b all inputs
        put(OP_CB1,   SEL_PORT_B, 8'h00, 1'b0, 8'h00, 8'h00);  // falling, sets flag
        put(OP_WRITE, SEL_CTRL_B, 8'h3d, 1'b0, 8'h00, 8'h00);
        put(OP_WRITE, SEL_PORT_B, 8'hff, 1'b0, 8'h00, 8'h00);
        put(OP_READ,  SEL_PORT_B, 8'h00, 1'b0, 8'h00, 8'haa);
        put(OP_READ,  SEL_CTRL_B, 8'h00, 1'b0, 8'h00, 8'h00);
        put(OP_WRITE, SEL_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00);  // cx2 back to input
        put(OP_READ,  SEL_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00);

        hold_until_drained();

        // random part; a stretch in the middle runs with no idling on either side
        for (int n = 0; n < 1900; n++)
        begin
            if (n == 400)
                steady <= 1'b1;
            if (n == 900)
                steady <= 1'b0;
            if (n == 1300)
                hold_until_drained();
            send_word(random_word());
        end

        item_valid <= 1'b0;
        @(posedge clk);
        while (mirror.predicted.size() != 0) @(posedge clk);
        // keep the clock running to catch any stray result word
        repeat (10) @(posedge clk);

        if (mirror.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pia_pkg.sv
hdl/pia_core.sv
hdl/parallel_interface_adapter.sv
verif/testbench.sv
